>>> rtl/core/rumg_pkg.sv
package rumg_pkg;

	localparam int MAX_DIM   = 4096;
	localparam int FRAC_BITS = 8;

	// register indexes
	localparam logic [2:0] REG_INV_PROJ_ROW0       = 3'd0;
	localparam logic [2:0] REG_INV_PROJ_ROW1       = 3'd1;
	localparam logic [2:0] REG_INV_PROJ_ROW2       = 3'd2;
	localparam logic [2:0] REG_RADIAL_COEFFS       = 3'd3;
	localparam logic [2:0] REG_TANGENTIAL_COEFFS   = 3'd4;
	localparam logic [2:0] REG_FOCAL_SKEW_CENTER_X = 3'd5;
	localparam logic [2:0] REG_FOCAL_CENTER_Y      = 3'd6;
	localparam logic [2:0] REG_IMAGE_SIZE          = 3'd7;

	// projected component, normalized coordinate, distorted coordinate
	localparam int T_W  = 35;
	localparam int NX_W = 25;
	localparam int EC_W = 32;

	typedef struct packed {
		logic [11:0] pixel_col;
		logic [11:0] pixel_row;
	} pix_t;

	typedef struct packed {
		logic [19:0] map_x;
		logic [19:0] map_y;
		logic        in_bounds;
	} map_t;

	typedef struct packed {
		logic [62:0] inv_proj_row0;
		logic [62:0] inv_proj_row1;
		logic [62:0] inv_proj_row2;
		logic [62:0] radial_coeffs;
		logic [62:0] tangential_coeffs;
		logic [62:0] focal_skew_center_x;
		logic [63:0] focal_center_y;
		logic [25:0] image_size;
	} cfg_t;

	// travels with each word down the pipeline
	typedef struct packed {
		logic valid;
		logic ok;
	} tag_t;

endpackage

>>> rtl/core/rumg_proj.sv
module rumg_proj import rumg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  v_in,
	input  pix_t                  pix,
	input  cfg_t                  cfg,
	output tag_t                  tag_out,
	output logic signed [T_W-1:0] t0,
	output logic signed [T_W-1:0] t1,
	output logic signed [T_W-1:0] t2
);

	logic [12:0] img_w, img_h;
	logic        size_ok, pix_ok;
	logic [62:0] rows [3];

	tag_t               tag_s1, tag_s2;
	logic signed [33:0] pc_s1 [3];
	logic signed [33:0] pr_s1 [3];
	logic signed [T_W-1:0] t_s2 [3];

	assign img_w = cfg.image_size[12:0];
	assign img_h = cfg.image_size[25:13];
	assign size_ok = (img_w != 13'd0) && (img_h != 13'd0)
		&& ({1'b0, img_w} <= 14'(MAX_DIM)) && ({1'b0, img_h} <= 14'(MAX_DIM));
	assign pix_ok = ({1'b0, pix.pixel_col} < img_w) && ({1'b0, pix.pixel_row} < img_h);

	assign rows[0] = cfg.inv_proj_row0;
	assign rows[1] = cfg.inv_proj_row1;
	assign rows[2] = cfg.inv_proj_row2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else if (en) begin
			tag_s1 <= '{valid: v_in, ok: size_ok && pix_ok};
			tag_s2 <= tag_s1;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_row
		logic signed [20:0] c_col, c_row, c_one;
		assign c_col = $signed(rows[i][20:0]);
		assign c_row = $signed(rows[i][41:21]);
		assign c_one = $signed(rows[i][62:42]);

		always_ff @(posedge clk) begin
			if (en) begin
				pc_s1[i] <= c_col * $signed({1'b0, pix.pixel_col});
				pr_s1[i] <= c_row * $signed({1'b0, pix.pixel_row});
				t_s2[i]  <= T_W'(pc_s1[i]) + T_W'(pr_s1[i]) + T_W'(c_one);
			end
		end
	end

	assign tag_out = tag_s2;
	assign t0 = t_s2[0];
	assign t1 = t_s2[1];
	assign t2 = t_s2[2];

endmodule

>>> rtl/core/rumg_div.sv
module rumg_div import rumg_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  tag_t                   tag_in,
	input  logic signed [T_W-1:0]  t0,
	input  logic signed [T_W-1:0]  t1,
	input  logic signed [T_W-1:0]  t2,
	output tag_t                   tag_out,
	output logic signed [NX_W-1:0] nx,
	output logic signed [NX_W-1:0] ny
);

	// quotient bits: 24 result bits plus one that flags saturation
	localparam int Q_BITS = NX_W;
	localparam int MAG_W  = T_W - 1;
	localparam int NUM_W  = MAG_W + 20;
	localparam int SH_W   = NUM_W + Q_BITS;
	localparam logic [Q_BITS-1:0] Q_LIM = Q_BITS'(1) << (Q_BITS - 2);

	logic [MAG_W-1:0] mag0, mag1, mag2;

	tag_t              tag_s  [0:Q_BITS];
	logic [NUM_W-1:0]  rem0_s [0:Q_BITS];
	logic [NUM_W-1:0]  rem1_s [0:Q_BITS];
	logic [Q_BITS-1:0] q0_s   [0:Q_BITS];
	logic [Q_BITS-1:0] q1_s   [0:Q_BITS];
	logic [MAG_W-1:0]  den_s  [0:Q_BITS];
	logic              sg0_s  [0:Q_BITS];
	logic              sg1_s  [0:Q_BITS];

	tag_t                   tag_s27;
	logic signed [NX_W-1:0] nx_s27, ny_s27;

	logic [Q_BITS-2:0]      qm0, qm1;
	logic signed [NX_W-1:0] sm0, sm1;

	assign mag0 = t0[T_W-1] ? MAG_W'(-t0) : t0[MAG_W-1:0];
	assign mag1 = t1[T_W-1] ? MAG_W'(-t1) : t1[MAG_W-1:0];
	assign mag2 = t2[T_W-1] ? MAG_W'(-t2) : t2[MAG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s[0] <= '0;
		end else if (en) begin
			tag_s[0] <= '{valid: tag_in.valid, ok: tag_in.ok && (t2 != '0)};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem0_s[0] <= {mag0, 20'b0};
			rem1_s[0] <= {mag1, 20'b0};
			q0_s[0]   <= '0;
			q1_s[0]   <= '0;
			den_s[0]  <= mag2;
			sg0_s[0]  <= t0[T_W-1] ^ t2[T_W-1];
			sg1_s[0]  <= t1[T_W-1] ^ t2[T_W-1];
		end
	end

	// restoring division, one quotient bit per stage, top bit first
	for (genvar k = 1; k <= Q_BITS; k++) begin : g_step
		localparam int B = Q_BITS - k;
		logic [SH_W-1:0] dsh;
		logic            ge0, ge1;

		assign dsh = SH_W'(den_s[k-1]) << B;
		assign ge0 = SH_W'(rem0_s[k-1]) >= dsh;
		assign ge1 = SH_W'(rem1_s[k-1]) >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k] <= '0;
			end else if (en) begin
				tag_s[k] <= tag_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem0_s[k] <= ge0 ? NUM_W'(SH_W'(rem0_s[k-1]) - dsh) : rem0_s[k-1];
				rem1_s[k] <= ge1 ? NUM_W'(SH_W'(rem1_s[k-1]) - dsh) : rem1_s[k-1];
				q0_s[k]   <= q0_s[k-1] | (ge0 ? (Q_BITS'(1) << B) : '0);
				q1_s[k]   <= q1_s[k-1] | (ge1 ? (Q_BITS'(1) << B) : '0);
				den_s[k]  <= den_s[k-1];
				sg0_s[k]  <= sg0_s[k-1];
				sg1_s[k]  <= sg1_s[k-1];
			end
		end
	end

	// clamp the magnitude to 8.0, then restore the sign
	assign qm0 = (q0_s[Q_BITS] > Q_LIM) ? Q_LIM[Q_BITS-2:0] : q0_s[Q_BITS][Q_BITS-2:0];
	assign qm1 = (q1_s[Q_BITS] > Q_LIM) ? Q_LIM[Q_BITS-2:0] : q1_s[Q_BITS][Q_BITS-2:0];
	assign sm0 = $signed({1'b0, qm0});
	assign sm1 = $signed({1'b0, qm1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s27 <= '0;
		end else if (en) begin
			tag_s27 <= tag_s[Q_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s27 <= sg0_s[Q_BITS] ? -sm0 : sm0;
			ny_s27 <= sg1_s[Q_BITS] ? -sm1 : sm1;
		end
	end

	assign tag_out = tag_s27;
	assign nx = nx_s27;
	assign ny = ny_s27;

	a_nx_range: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s27.valid |-> (nx_s27 <= $signed({1'b0, Q_LIM}))
			&& (nx_s27 >= -$signed({1'b0, Q_LIM})))
		else $error("normalized x beyond saturation limit");

endmodule

>>> rtl/core/rumg_distort.sv
module rumg_distort import rumg_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  cfg_t                   cfg,
	input  tag_t                   tag_in,
	input  logic signed [NX_W-1:0] nx,
	input  logic signed [NX_W-1:0] ny,
	output tag_t                   tag_out,
	output logic signed [EC_W-1:0] xe,
	output logic signed [EC_W-1:0] ye
);

	localparam logic signed [63:0] ONE_Q20 = 64'sd1048576;
	localparam logic signed [63:0] LIM31   = 64'sd2147483647;

	function automatic logic signed [EC_W-1:0] sat31(input logic signed [63:0] v);
		logic signed [63:0] c;
		c = v;
		if (v > LIM31) c = LIM31;
		if (v < -LIM31) c = -LIM31;
		return EC_W'(c);
	endfunction

	logic signed [20:0] k1, k2, k3;
	logic signed [31:0] p1;
	logic signed [30:0] p2;

	assign k1 = $signed(cfg.radial_coeffs[20:0]);
	assign k2 = $signed(cfg.radial_coeffs[41:21]);
	assign k3 = $signed(cfg.radial_coeffs[62:42]);
	assign p1 = $signed(cfg.tangential_coeffs[31:0]);
	assign p2 = $signed(cfg.tangential_coeffs[62:32]);

	tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7, tag_s8, tag_s9;

	logic signed [NX_W-1:0] nx_s1, ny_s1, nx_s2, ny_s2, nx_s3, ny_s3, nx_s4, ny_s4;
	logic signed [NX_W-1:0] nx_s5, ny_s5, nx_s6, ny_s6, nx_s7, ny_s7;
	logic signed [49:0] sqx_s1, sqy_s1, pxy_s1;
	logic signed [28:0] r_s2, xx_s2, yy_s2, xy_s2;
	logic signed [28:0] r_s3, xy_s3, r_s4;
	logic signed [57:0] rr_s3;
	logic signed [30:0] rx_s3, ry_s3;
	logic signed [49:0] k1r_s3, k1r_s4, k1r_s5, k1r_s6;
	logic signed [35:0] r2_s4;
	logic signed [60:0] tp1_s4, tp2_s4;
	logic signed [62:0] tpx_s4, tpy_s4;
	logic signed [63:0] r2r_s5;
	logic signed [56:0] k2r2_s5, k2r2_s6;
	logic signed [63:0] tx_s5, ty_s5;
	logic signed [63:0] k3r3_s6;
	logic signed [36:0] txs_s6, tys_s6, txs_s7, tys_s7, txs_s8, tys_s8;
	logic signed [EC_W-1:0] rad_s7;
	logic signed [56:0] nxr_s8, nyr_s8;
	logic signed [EC_W-1:0] xe_s9, ye_s9;

	logic signed [42:0] r3;
	logic signed [63:0] ksum;

	assign r3   = 43'(r2r_s5 >>> 20);
	assign ksum = 64'(k1r_s6) + 64'(k2r2_s6) + k3r3_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0; tag_s2 <= '0; tag_s3 <= '0;
			tag_s4 <= '0; tag_s5 <= '0; tag_s6 <= '0;
			tag_s7 <= '0; tag_s8 <= '0; tag_s9 <= '0;
		end else if (en) begin
			tag_s1 <= tag_in; tag_s2 <= tag_s1; tag_s3 <= tag_s2;
			tag_s4 <= tag_s3; tag_s5 <= tag_s4; tag_s6 <= tag_s5;
			tag_s7 <= tag_s6; tag_s8 <= tag_s7; tag_s9 <= tag_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// squares and cross term
			sqx_s1 <= nx * nx;
			sqy_s1 <= ny * ny;
			pxy_s1 <= nx * ny;
			nx_s1  <= nx;
			ny_s1  <= ny;
			// back to Q.20
			r_s2  <= 29'((51'(sqx_s1) + 51'(sqy_s1)) >>> 20);
			xx_s2 <= 29'(sqx_s1 >>> 20);
			yy_s2 <= 29'(sqy_s1 >>> 20);
			xy_s2 <= 29'(pxy_s1 >>> 20);
			nx_s2 <= nx_s1;
			ny_s2 <= ny_s1;
			// r squared, first radial product
			rr_s3  <= r_s2 * r_s2;
			k1r_s3 <= k1 * r_s2;
			rx_s3  <= 31'(r_s2) + (31'(xx_s2) <<< 1);
			ry_s3  <= 31'(r_s2) + (31'(yy_s2) <<< 1);
			r_s3   <= r_s2;
			xy_s3  <= xy_s2;
			nx_s3  <= nx_s2;
			ny_s3  <= ny_s2;
			// tangential products
			r2_s4  <= 36'(rr_s3 >>> 20);
			tp1_s4 <= p1 * xy_s3;
			tp2_s4 <= p2 * xy_s3;
			tpx_s4 <= p2 * rx_s3;
			tpy_s4 <= p1 * ry_s3;
			r_s4   <= r_s3;
			k1r_s4 <= k1r_s3;
			nx_s4  <= nx_s3;
			ny_s4  <= ny_s3;
			// r cubed product, second radial product
			r2r_s5  <= 64'(r2_s4 * r_s4);
			k2r2_s5 <= k2 * r2_s4;
			tx_s5   <= (64'(tp1_s4) <<< 1) + 64'(tpx_s4);
			ty_s5   <= (64'(tp2_s4) <<< 1) + 64'(tpy_s4);
			k1r_s5  <= k1r_s4;
			nx_s5   <= nx_s4;
			ny_s5   <= ny_s4;
			// third radial product
			k3r3_s6 <= 64'(k3 * r3);
			txs_s6  <= 37'(tx_s5 >>> 27);
			tys_s6  <= 37'(ty_s5 >>> 27);
			k1r_s6  <= k1r_s5;
			k2r2_s6 <= k2r2_s5;
			nx_s6   <= nx_s5;
			ny_s6   <= ny_s5;
			// radial factor
			rad_s7 <= sat31(ONE_Q20 + (ksum >>> 17));
			txs_s7 <= txs_s6;
			tys_s7 <= tys_s6;
			nx_s7  <= nx_s6;
			ny_s7  <= ny_s6;
			// scale by radial factor
			nxr_s8 <= nx_s7 * rad_s7;
			nyr_s8 <= ny_s7 * rad_s7;
			txs_s8 <= txs_s7;
			tys_s8 <= tys_s7;
			// distorted coordinates
			xe_s9 <= sat31(64'(nxr_s8 >>> 20) + 64'(txs_s8));
			ye_s9 <= sat31(64'(nyr_s8 >>> 20) + 64'(tys_s8));
		end
	end

	assign tag_out = tag_s9;
	assign xe = xe_s9;
	assign ye = ye_s9;

endmodule

>>> rtl/core/rumg_intr.sv
module rumg_intr import rumg_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  cfg_t                   cfg,
	input  tag_t                   tag_in,
	input  logic signed [EC_W-1:0] xe,
	input  logic signed [EC_W-1:0] ye,
	output logic                   v_out,
	output map_t                   map_out
);

	logic signed [20:0] fx, skew, cx;
	logic signed [31:0] fy, cy;
	logic [12:0]        img_w, img_h;
	logic signed [55:0] x_lim;
	logic signed [63:0] y_lim;
	logic               inb;

	tag_t               tag_s1, tag_s2, tag_s3;
	logic signed [52:0] fxe_s1, ske_s1;
	logic signed [63:0] fye_s1;
	logic signed [55:0] x_s2;
	logic signed [63:0] y_s2;
	map_t               map_s3;

	assign fx    = $signed(cfg.focal_skew_center_x[20:0]);
	assign skew  = $signed(cfg.focal_skew_center_x[41:21]);
	assign cx    = $signed(cfg.focal_skew_center_x[62:42]);
	assign fy    = $signed(cfg.focal_center_y[31:0]);
	assign cy    = $signed(cfg.focal_center_y[63:32]);
	assign img_w = cfg.image_size[12:0];
	assign img_h = cfg.image_size[25:13];

	assign x_lim = 56'({img_w - 13'd1, 27'b0});
	assign y_lim = 64'({img_h - 13'd1, 36'b0});
	assign inb = tag_s2.ok && (x_s2 >= 0) && (y_s2 >= 0) && (x_s2 <= x_lim) && (y_s2 <= y_lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (en) begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fxe_s1 <= fx * xe;
			ske_s1 <= skew * ye;
			fye_s1 <= fy * ye;
			x_s2   <= 56'(fxe_s1) + 56'(ske_s1) + (56'(cx) <<< 20);
			y_s2   <= fye_s1 + (64'(cy) <<< 20);
			map_s3.in_bounds <= inb;
			map_s3.map_x     <= inb ? x_s2[27-FRAC_BITS +: 20] : 20'd0;
			map_s3.map_y     <= inb ? y_s2[36-FRAC_BITS +: 20] : 20'd0;
		end
	end

	assign v_out   = tag_s3.valid;
	assign map_out = map_s3;

endmodule

>>> rtl/core/rectify_undistort_map_generator.sv
// Rectify / undistort map generator for one camera.
// Pixel channel: pix_valid, pix_stall, pix_word (rectified column and row).
// Map channel: map_valid, map_stall, map_word (source x, y in Q12.8, in_bounds).
// A word moves at a clock edge where valid is high and stall is low.
// Configuration: cfg_we, cfg_index, cfg_data write one register per edge;
// write only while the pipeline is empty.
// A pixel passes through the projection, the pipelined divider (one quotient
// bit per stage), distortion, and the intrinsics and bounds check, in that
// order. One word per cycle enters and leaves while the pipeline is not frozen.
// When map_stall holds a map word, the whole pipeline freezes in place and
// pix_stall rises in the same cycle; nothing is lost or repeated.
// Out-of-image or degenerate points give in_bounds 0 with zero coordinates.
// Reset clears the configuration and the valid tags and empties the pipeline; data registers are not reset.
module rectify_undistort_map_generator import rumg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pix_valid,
	output logic        pix_stall,
	input  pix_t        pix_word,
	output logic        map_valid,
	input  logic        map_stall,
	output map_t        map_word,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	cfg_t cfg_q;
	logic en;

	tag_t                   tag_p, tag_d, tag_e;
	logic signed [T_W-1:0]  t0, t1, t2;
	logic signed [NX_W-1:0] nx, ny;
	logic signed [EC_W-1:0] xe, ye;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INV_PROJ_ROW0:       cfg_q.inv_proj_row0       <= cfg_data[62:0];
				REG_INV_PROJ_ROW1:       cfg_q.inv_proj_row1       <= cfg_data[62:0];
				REG_INV_PROJ_ROW2:       cfg_q.inv_proj_row2       <= cfg_data[62:0];
				REG_RADIAL_COEFFS:       cfg_q.radial_coeffs       <= cfg_data[62:0];
				REG_TANGENTIAL_COEFFS:   cfg_q.tangential_coeffs   <= cfg_data[62:0];
				REG_FOCAL_SKEW_CENTER_X: cfg_q.focal_skew_center_x <= cfg_data[62:0];
				REG_FOCAL_CENTER_Y:      cfg_q.focal_center_y      <= cfg_data;
				REG_IMAGE_SIZE:          cfg_q.image_size          <= cfg_data[25:0];
			endcase
		end
	end

	// pipeline moves unless a finished word is held
	assign en = !(map_valid && map_stall);
	assign pix_stall = !en;

	rumg_proj u_proj (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (pix_valid),
		.pix     (pix_word),
		.cfg     (cfg_q),
		.tag_out (tag_p),
		.t0      (t0),
		.t1      (t1),
		.t2      (t2)
	);

	rumg_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.tag_in  (tag_p),
		.t0      (t0),
		.t1      (t1),
		.t2      (t2),
		.tag_out (tag_d),
		.nx      (nx),
		.ny      (ny)
	);

	rumg_distort u_distort (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.cfg     (cfg_q),
		.tag_in  (tag_d),
		.nx      (nx),
		.ny      (ny),
		.tag_out (tag_e),
		.xe      (xe),
		.ye      (ye)
	);

	rumg_intr u_intr (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.cfg     (cfg_q),
		.tag_in  (tag_e),
		.xe      (xe),
		.ye      (ye),
		.v_out   (map_valid),
		.map_out (map_word)
	);

	a_zero_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		map_valid && !map_word.in_bounds |-> map_word.map_x == '0 && map_word.map_y == '0)
		else $error("invalid map word carries nonzero coordinates");

	a_size_ok: assert property (@(posedge clk) disable iff (!arst_n)
		map_valid && map_word.in_bounds
			|-> cfg_q.image_size[12:0] != '0 && cfg_q.image_size[25:13] != '0)
		else $error("in-bounds word with empty image size");

endmodule

>>> verif/tb_rectify_undistort_map_generator.sv
`timescale 1ns / 1ps

module tb_rectify_undistort_map_generator;
	import rumg_pkg::*;

	localparam longint LIM31 = 64'sd2147483647;
	localparam longint LIM23 = 64'sd8388608;
	localparam int WATCHDOG_LIMIT = 20000;

	class map_scoreboard;
		logic [63:0] regs [8];
		map_t expected_maps[$];
		int errors;

		function new();
			foreach (regs[i]) regs[i] = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [63:0] val);
			if (idx == REG_FOCAL_CENTER_Y)
				regs[idx] = val;
			else if (idx == REG_IMAGE_SIZE)
				regs[idx] = val & 64'h3FF_FFFF;
			else
				regs[idx] = val & 64'h7FFF_FFFF_FFFF_FFFF;
		endfunction

		function longint sfield(logic [63:0] v, int pos, int w);
			longint f, m;
			m = longint'(64'd1 << (w - 1));
			f = longint'((v >> pos) & ((64'd1 << w) - 64'd1));
			return (f ^ m) - m;
		endfunction

		function longint clip(longint v, longint lim);
			if (v > lim) return lim;
			if (v < -lim) return -lim;
			return v;
		endfunction

		function longint row_dot(logic [63:0] r, longint c, longint w);
			return sfield(r, 0, 21) * c + sfield(r, 21, 21) * w + sfield(r, 42, 21);
		endfunction

		function map_t source_coord(pix_t p);
			longint col, row, wd, ht, t0, t1, t2, nx, ny, r, r2, r3, rad;
			longint xy, xx, yy, xe, ye, x, y, k1, k2, k3, p1, p2;
			map_t m;
			m = '0;
			col = longint'(p.pixel_col);
			row = longint'(p.pixel_row);
			wd = longint'(regs[REG_IMAGE_SIZE][12:0]);
			ht = longint'(regs[REG_IMAGE_SIZE][25:13]);
			if (wd == 0 || ht == 0 || wd > MAX_DIM || ht > MAX_DIM) return m;
			if (col >= wd || row >= ht) return m;
			t0 = row_dot(regs[REG_INV_PROJ_ROW0], col, row);
			t1 = row_dot(regs[REG_INV_PROJ_ROW1], col, row);
			t2 = row_dot(regs[REG_INV_PROJ_ROW2], col, row);
			if (t2 == 0) return m;
			nx = clip((t0 * 1048576) / t2, LIM23);
			ny = clip((t1 * 1048576) / t2, LIM23);
			// all shifts floor, >>> on signed does that
			r = (nx * nx + ny * ny) >>> 20;
			r2 = (r * r) >>> 20;
			r3 = (r2 * r) >>> 20;
			k1 = sfield(regs[REG_RADIAL_COEFFS], 0, 21);
			k2 = sfield(regs[REG_RADIAL_COEFFS], 21, 21);
			k3 = sfield(regs[REG_RADIAL_COEFFS], 42, 21);
			rad = clip(1048576 + ((k1 * r + k2 * r2 + k3 * r3) >>> 17), LIM31);
			p1 = sfield(regs[REG_TANGENTIAL_COEFFS], 0, 32);
			p2 = sfield(regs[REG_TANGENTIAL_COEFFS], 32, 31);
			xy = (nx * ny) >>> 20;
			xx = (nx * nx) >>> 20;
			yy = (ny * ny) >>> 20;
			xe = ((nx * rad) >>> 20) + ((2 * p1 * xy + p2 * (r + 2 * xx)) >>> 27);
			ye = ((ny * rad) >>> 20) + ((2 * p2 * xy + p1 * (r + 2 * yy)) >>> 27);
			xe = clip(xe, LIM31);
			ye = clip(ye, LIM31);
			x = sfield(regs[REG_FOCAL_SKEW_CENTER_X], 0, 21) * xe
				+ sfield(regs[REG_FOCAL_SKEW_CENTER_X], 21, 21) * ye
				+ sfield(regs[REG_FOCAL_SKEW_CENTER_X], 42, 21) * 1048576;
			y = sfield(regs[REG_FOCAL_CENTER_Y], 0, 32) * ye
				+ sfield(regs[REG_FOCAL_CENTER_Y], 32, 32) * 1048576;
			if (x < 0 || y < 0) return m;
			if (x > (wd - 1) * 64'sd134217728) return m;
			if (y > (ht - 1) * 64'sd68719476736) return m;
			m.map_x = 20'(64'(x) >> (27 - FRAC_BITS));
			m.map_y = 20'(64'(y) >> (36 - FRAC_BITS));
			m.in_bounds = 1'b1;
			return m;
		endfunction

		function void note_pixel(pix_t p);
			expected_maps.push_back(source_coord(p));
		endfunction

		task report(string what, logic [19:0] got, logic [19:0] exp);
			$display("mismatch %s: got %0h expected %0h", what, got, exp);
			errors++;
		endtask

		task check_map(map_t got);
			map_t exp;
			if (expected_maps.size() == 0) begin
				report("unexpected word", got.map_x, '0);
				return;
			end
			exp = expected_maps.pop_front();
			if (got.map_x !== exp.map_x) report("map_x", got.map_x, exp.map_x);
			if (got.map_y !== exp.map_y) report("map_y", got.map_y, exp.map_y);
			if (got.in_bounds !== exp.in_bounds)
				report("in_bounds", 20'(got.in_bounds), 20'(exp.in_bounds));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        pix_valid = 1'b0;
	logic        pix_stall;
	pix_t        pix_word = '0;
	logic        map_valid;
	logic        map_stall = 1'b0;
	map_t        map_word;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	map_scoreboard sb = new();
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	int quiet_cycles = 0;
	logic [63:0] cfg_set [8];

	rectify_undistort_map_generator dut (.*);

	always #1 clk = ~clk;

	// receiver: check accepted words, then pick next stall
	always @(posedge clk) begin
		if (arst_n && map_valid && !map_stall) sb.check_map(map_word);
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			map_stall <= 1'b1;
		end else
			map_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((pix_valid && !pix_stall) || (map_valid && !map_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("** rectify_undistort_map_generator: FAILED **");
			$finish;
		end
	end

	function logic [62:0] pack3(int a, int b, int c);
		return {21'(c), 21'(b), 21'(a)};
	endfunction

	function int srand(int lim);
		return int'($urandom_range(2 * lim)) - lim;
	endfunction

	task send_pixel(logic [11:0] col, logic [11:0] row);
		pix_t p;
		p.pixel_col = col;
		p.pixel_row = row;
		while ($urandom_range(99) < sender_idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix_word <= p;
		do @(posedge clk); while (pix_stall);
		sb.note_pixel(p);
	endtask

	task drain;
		pix_valid <= 1'b0;
		while (sb.expected_maps.size() != 0) @(posedge clk);
		repeat (45) @(posedge clk);
	endtask

	task load_config;
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= cfg_set[i];
			@(posedge clk);
			sb.write_reg(3'(i), cfg_set[i]);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// pinhole camera centered on the image, with mild random distortion
	task camera_config(int wd, int ht);
		int s, f;
		s = $urandom_range(1, 4);
		f = $urandom_range(100, 2000);
		cfg_set[REG_INV_PROJ_ROW0] = pack3(s, 0, -s * (wd / 2));
		cfg_set[REG_INV_PROJ_ROW1] = pack3(0, s, -s * (ht / 2));
		cfg_set[REG_INV_PROJ_ROW2] = pack3(0, 0, s * f);
		cfg_set[REG_RADIAL_COEFFS] = pack3(srand(40000), srand(10000), srand(3000));
		cfg_set[REG_TANGENTIAL_COEFFS] = {1'b0, 31'(srand(150000)), 32'(srand(150000))};
		cfg_set[REG_FOCAL_SKEW_CENTER_X] = pack3(f * 128, srand(200), (wd / 2) * 128);
		cfg_set[REG_FOCAL_CENTER_Y] = {32'((ht / 2) << 16), 32'(f << 16)};
		cfg_set[REG_IMAGE_SIZE] = {38'd0, 13'(ht), 13'(wd)};
	endtask

	task noise_config;
		for (int i = 0; i < 8; i++) cfg_set[i] = {$urandom, $urandom};
		cfg_set[REG_IMAGE_SIZE] = {38'd0, 13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096))};
	endtask

	task corner_pixels(int wd, int ht);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'hFFF, 12'hFFF);
		send_pixel(12'(wd - 1), 12'(ht - 1));
		send_pixel(12'(wd), 12'(ht / 2));
		send_pixel(12'(wd / 2), 12'(ht));
	endtask

	initial begin
		int wd, ht;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero image size with an otherwise good camera
		camera_config(640, 480);
		cfg_set[REG_IMAGE_SIZE] = '0;
		load_config();
		corner_pixels(640, 480);
		drain();
		// oversized image and a degenerate third row
		camera_config(640, 480);
		cfg_set[REG_INV_PROJ_ROW2] = '0;
		cfg_set[REG_IMAGE_SIZE] = {38'd0, 13'h1FFF, 13'd640};
		load_config();
		corner_pixels(640, 480);
		drain();
		cfg_set[REG_IMAGE_SIZE] = {38'd0, 13'd480, 13'd640};
		load_config();
		corner_pixels(640, 480);
		drain();
		// well-formed camera at the largest legal size
		camera_config(4096, 4096);
		load_config();
		corner_pixels(4096, 4096);
		send_pixel(12'd2048, 12'd2048);
		drain();
		// every register set to all ones, but the image size at 4096 by 4096
		for (int i = 0; i < 8; i++) cfg_set[i] = '1;
		cfg_set[REG_IMAGE_SIZE] = {38'd0, 13'd4096, 13'd4096};
		load_config();
		corner_pixels(4096, 4096);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin sender_idle_pct = 82; recv_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  recv_stall_pct = 82; end
				default: begin sender_idle_pct = 23; recv_stall_pct = 23; end
			endcase
			if (ph == 3 || ph == 7) begin
				noise_config();
				wd = cfg_set[REG_IMAGE_SIZE][12:0];
				ht = cfg_set[REG_IMAGE_SIZE][25:13];
			end else begin
				wd = ($urandom_range(3) == 0) ? $urandom_range(16, 4096) : $urandom_range(16, 800);
				ht = ($urandom_range(3) == 0) ? $urandom_range(16, 4096) : $urandom_range(16, 800);
				camera_config(wd, ht);
			end
			load_config();
			if (ph == 4) begin
				sender_idle_pct = 0;
				hold_cycles = 300;
			end
			for (int n = 0; n < 85; n++) begin
				if (ph == 5 && n == 40) begin
					// sender pauses until the pipe is empty
					pix_valid <= 1'b0;
					while (sb.expected_maps.size() != 0) @(posedge clk);
				end
				if ($urandom_range(99) < 85)
					send_pixel(12'($urandom_range(wd - 1)), 12'($urandom_range(ht - 1)));
				else
					send_pixel(12'($urandom), 12'($urandom));
			end
			drain();
		end

		repeat (60) @(posedge clk);
		if (sb.expected_maps.size() != 0) sb.report("missing words", 20'(sb.expected_maps.size()), '0);
		if (sb.errors == 0)
			$display("** rectify_undistort_map_generator: PASSED **");
		else
			$display("** rectify_undistort_map_generator: FAILED **");
		$finish;
	end

endmodule

>>> rectify_undistort_map_generator.f
rtl/core/rumg_pkg.sv
rtl/core/rumg_proj.sv
rtl/core/rumg_div.sv
rtl/core/rumg_distort.sv
rtl/core/rumg_intr.sv
rtl/core/rectify_undistort_map_generator.sv
verif/tb_rectify_undistort_map_generator.sv
